/* rtl/assert_macros.svh */
// Assertion helpers for the RTL in segment_clearance_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SCC_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("%m: check failed");

// Condition in one cycle implies a condition in the next.
`define SCC_ASSERT_NEXT(lbl, ck, rn, cause, effect) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cause) |=> (effect)) \
    else $error("%m: check failed");

`endif

/* rtl/scc_pkg.sv */
package scc_pkg;

  localparam int GRID_CELLS_DEF  = 65536;
  localparam int MAX_SAMPLES_DEF = 1024;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SPACING     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_NO_DATA     = 3'd6;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD   = 3'd7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [15:0] GRID_WIDTH_RST  = 16'd256;
  localparam logic [15:0] GRID_HEIGHT_RST = 16'd256;
  localparam logic [30:0] CELL_SIZE_RST   = 31'd3277;
  localparam logic [30:0] SPACING_RST     = 31'd13107;
  localparam logic [7:0]  NO_DATA_RST     = 8'h80;
  localparam logic [6:0]  THRESHOLD_RST   = 7'd50;

  localparam int IN_DW  = 184;
  localparam int OUT_DW = 8;

  localparam int LENW = 33;   // segment length
  localparam int SRW  = 36;   // square root remainder
  localparam int SQW  = 66;   // squared length radicand
  localparam int MULW = 33;   // shared multiplier operands
  localparam int NMW  = 34;   // divider numerator magnitude
  localparam int QW   = 35;   // signed quotient, cell coordinates
  localparam int DVW  = 31;   // divisor
  localparam int CNTW = 6;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_SQ1     = 15'b000000000000010,
    ST_SQ2     = 15'b000000000000100,
    ST_SQRT    = 15'b000000000001000,
    ST_DV_LOAD = 15'b000000000010000,
    ST_DV_RUN  = 15'b000000000100000,
    ST_DV_END  = 15'b000000001000000,
    ST_NCHK    = 15'b000000010000000,
    ST_ECN     = 15'b000000100000000,
    ST_NLEN    = 15'b000001000000000,
    ST_MAPV    = 15'b000010000000000,
    ST_ADDR    = 15'b000100000000000,
    ST_READ    = 15'b001000000000000,
    ST_EVAL    = 15'b010000000000000,
    ST_DONE    = 15'b100000000000000
  } state_t;

  typedef enum logic [2:0] {
    OP_N  = 3'd0,
    OP_DX = 3'd1,
    OP_DY = 3'd2,
    OP_X0 = 3'd3,
    OP_Y0 = 3'd4,
    OP_AX = 3'd5,
    OP_AY = 3'd6
  } div_op_t;

endpackage

/* rtl/segment_clearance_check.sv */
// Occupancy grid with a segment clearance query. A write word (tuser 0) stores one cell.
// A query word (tuser 1) finds the length by a bit-serial square root, then runs up to
// seven divisions through one shared shift-subtract divider (sample count, per-axis
// sample step, start cell and cell step), and walks the n+1 samples (address, grid
// read, evaluate); a too-long query ends after the sample count division and an
// invalid map skips four divisions. The input is not ready while a query runs; a
// result waits in the output register while the next word is taken.
`include "assert_macros.svh"

module segment_clearance_check
  import scc_pkg::*;
#(
  parameter int GRID_CELLS  = GRID_CELLS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // cell_index, cell_value, start_x, start_y, end_x, end_y, end_clear, zero pad
  input  logic [IN_DW-1:0]  in_tdata,
  // cmd
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // clear, too_long, zero pad
  output logic [OUT_DW-1:0] out_tdata
);

  localparam int AW  = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int SW  = $clog2(MAX_SAMPLES + 1);
  localparam int ECW = DVW + SW;
  localparam int NLW = LENW + SW;

  // configuration
  logic [15:0]        grid_width_r, grid_height_r;
  logic [30:0]        cell_size_r, spacing_r;
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [7:0]         no_data_r;
  logic [6:0]         thr_r;

  state_t state_r, state_nxt;
  div_op_t dv_op_r;

  // input fields
  logic [15:0]        in_cell_index;
  logic [7:0]         in_cell_value;
  logic signed [31:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic [30:0]        in_end_clear;

  assign in_cell_index = in_tdata[15:0];
  assign in_cell_value = in_tdata[23:16];
  assign in_start_x    = in_tdata[55:24];
  assign in_start_y    = in_tdata[87:56];
  assign in_end_x      = in_tdata[119:88];
  assign in_end_y      = in_tdata[151:120];
  assign in_end_clear  = in_tdata[182:152];

  logic in_acc, wr_en, query_acc;
  logic [AW-1:0] wr_addr;

  // query datapath
  logic signed [31:0]  sx_r, sy_r;
  logic signed [32:0]  dx_r, dy_r;
  logic signed [32:0]  dx_in, dy_in;
  logic [31:0]         ax_abs_r, ay_abs_r;
  logic [30:0]         ec_r;
  logic [SQW-1:0]      sq_rad_r;
  logic [SRW-1:0]      sq_rem_r;
  logic [LENW-1:0]     sq_root_r, len_r;
  logic [CNTW-1:0]     cnt_r;
  logic [NMW-1:0]      dv_num_r, dv_quo_r;
  logic [DVW-1:0]      dv_rem_r, dv_den_r;
  logic                dv_neg_r;
  logic signed [QW-1:0] nq_r, qdx_r, qdy_r, stx_r, sty_r, gx_r, gy_r;
  logic [SW-1:0]       rdx_r, rdy_r, n_r, idx_r, rx_r, ry_r;
  logic [30:0]         bx_r, by_r, offx_r, offy_r;
  logic [ECW-1:0]      ecn_r;
  logic [NLW-1:0]      acc_up_r, acc_dn_r;
  logic                map_ok_r, inb_r, pfx_ok_r, sfx_ok_r;
  logic                pfx_r, pend_r, fail_r;
  logic [AW-1:0]       addr_r;
  logic [7:0]          rdata_r;
  logic                res_clear_r, res_tl_r;
  logic                out_tvalid_r, out_clear_r, out_tl_r;

  logic [7:0] grid_mem [GRID_CELLS];

  // shared multiplier
  logic [MULW-1:0]   mul_a, mul_b;
  logic [2*MULW-1:0] mul_p;

  // square root step
  logic [SRW-1:0]  sq_rem2, sq_rem_nxt;
  logic [LENW+1:0] sq_trial;
  logic            sq_ge;
  logic [LENW-1:0] sq_root_nxt;

  // divider
  logic [DVW-1:0]       sp_eff;
  logic signed [QW-1:0] ld_num;
  logic [QW-1:0]        ld_abs;
  logic [DVW-1:0]       ld_den;
  logic [DVW:0]         dv_trial;
  logic                 dv_ge;
  logic [DVW-1:0]       dv_rem_nxt;
  logic signed [QW-1:0] dv_q, dv_qmag;
  logic [DVW-1:0]       dv_r;

  // sample walk
  logic [31:0] addr_full;
  logic        inb, occ, in_pfx, pend_now, fail_nxt;
  logic [SW:0] rx_sum, ry_sum;
  logic        cx, cy, c2x, c2y;
  logic [31:0] ox_sum, oy_sum;
  logic        too_long;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign wr_en      = in_acc && (in_tuser == CMD_WRITE) &&
                      (32'(in_cell_index) < 32'(GRID_CELLS));
  assign query_acc  = in_acc && (in_tuser == CMD_QUERY);
  assign wr_addr    = AW'(in_cell_index);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_tl_r, out_clear_r};

  assign dx_in = 33'(in_end_x) - 33'(in_start_x);
  assign dy_in = 33'(in_end_y) - 33'(in_start_y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ1: begin
        mul_a = MULW'(ax_abs_r);
        mul_b = MULW'(ax_abs_r);
      end
      ST_SQ2: begin
        mul_a = MULW'(ay_abs_r);
        mul_b = MULW'(ay_abs_r);
      end
      ST_ECN: begin
        mul_a = MULW'(ec_r);
        mul_b = MULW'(n_r);
      end
      ST_NLEN: begin
        mul_a = len_r;
        mul_b = MULW'(n_r);
      end
      ST_MAPV: begin
        mul_a = MULW'(grid_width_r);
        mul_b = MULW'(grid_height_r);
      end
      ST_ADDR: begin
        mul_a = MULW'(gy_r[15:0]);
        mul_b = MULW'(grid_width_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    sq_rem2     = {sq_rem_r[SRW-3:0], sq_rad_r[SQW-1:SQW-2]};
    sq_trial    = {sq_root_r, 2'b01};
    sq_ge       = sq_rem2 >= SRW'(sq_trial);
    sq_rem_nxt  = sq_ge ? (sq_rem2 - SRW'(sq_trial)) : sq_rem2;
    sq_root_nxt = {sq_root_r[LENW-2:0], sq_ge};
  end

  always_comb begin
    sp_eff = (spacing_r == '0) ? DVW'(1) : spacing_r;
    case (dv_op_r)
      OP_N: begin
        ld_num = QW'(len_r) + QW'(sp_eff) - QW'(1);
        ld_den = sp_eff;
      end
      OP_DX: begin
        ld_num = QW'(dx_r);
        ld_den = DVW'(n_r);
      end
      OP_DY: begin
        ld_num = QW'(dy_r);
        ld_den = DVW'(n_r);
      end
      OP_X0: begin
        ld_num = QW'(sx_r) - QW'(origin_x_r);
        ld_den = cell_size_r;
      end
      OP_Y0: begin
        ld_num = QW'(sy_r) - QW'(origin_y_r);
        ld_den = cell_size_r;
      end
      OP_AX: begin
        ld_num = qdx_r;
        ld_den = cell_size_r;
      end
      OP_AY: begin
        ld_num = qdy_r;
        ld_den = cell_size_r;
      end
      default: begin
        ld_num = '0;
        ld_den = DVW'(1);
      end
    endcase
    ld_abs = ld_num[QW-1] ? QW'(-ld_num) : QW'(ld_num);

    dv_trial   = {dv_rem_r, dv_num_r[NMW-1]};
    dv_ge      = dv_trial >= {1'b0, dv_den_r};
    dv_rem_nxt = dv_ge ? DVW'(dv_trial - {1'b0, dv_den_r}) : DVW'(dv_trial);

    // floor toward minus infinity for a negative numerator
    dv_qmag = QW'(dv_quo_r);
    if (dv_neg_r && (dv_rem_r != '0)) begin
      dv_q = -(dv_qmag + QW'(1));
      dv_r = dv_den_r - dv_rem_r;
    end else if (dv_neg_r) begin
      dv_q = -dv_qmag;
      dv_r = '0;
    end else begin
      dv_q = dv_qmag;
      dv_r = dv_rem_r;
    end
  end

  assign too_long = nq_r > QW'(MAX_SAMPLES);

  always_comb begin
    inb = !gx_r[QW-1] && !gy_r[QW-1] && (gx_r < QW'(grid_width_r)) &&
          (gy_r < QW'(grid_height_r));
    addr_full = mul_p[31:0] + 32'(gx_r[15:0]);

    occ = !map_ok_r || !inb_r || (rdata_r == no_data_r) ||
          ($signed(rdata_r) >= $signed({1'b0, thr_r}));
    // leading occupied run near the start is skipped; once past it, every
    // occupied sample must begin a run that reaches the end within end_clear
    in_pfx   = pfx_r && occ && pfx_ok_r;
    pend_now = pend_r || occ;
    fail_nxt = fail_r || (!in_pfx && pend_now && !(occ && sfx_ok_r));

    rx_sum = {1'b0, rx_r} + {1'b0, rdx_r};
    ry_sum = {1'b0, ry_r} + {1'b0, rdy_r};
    cx     = rx_sum >= {1'b0, n_r};
    cy     = ry_sum >= {1'b0, n_r};
    ox_sum = {1'b0, offx_r} + {1'b0, bx_r} + 32'(cx);
    oy_sum = {1'b0, offy_r} + {1'b0, by_r} + 32'(cy);
    c2x    = ox_sum >= {1'b0, cell_size_r};
    c2y    = oy_sum >= {1'b0, cell_size_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (query_acc) state_nxt = ST_SQ1;
      ST_SQ1:     state_nxt = ST_SQ2;
      ST_SQ2:     state_nxt = ST_SQRT;
      ST_SQRT:    if (cnt_r == CNTW'(LENW - 1)) state_nxt = ST_DV_LOAD;
      ST_DV_LOAD: state_nxt = ST_DV_RUN;
      ST_DV_RUN:  if (cnt_r == CNTW'(NMW - 1)) state_nxt = ST_DV_END;
      ST_DV_END: begin
        case (dv_op_r)
          OP_N:    state_nxt = ST_NCHK;
          OP_DY:   state_nxt = map_ok_r ? ST_DV_LOAD : ST_ADDR;
          OP_AY:   state_nxt = ST_ADDR;
          default: state_nxt = ST_DV_LOAD;
        endcase
      end
      ST_NCHK:    state_nxt = too_long ? ST_DONE : ST_ECN;
      ST_ECN:     state_nxt = ST_NLEN;
      ST_NLEN:    state_nxt = ST_MAPV;
      ST_MAPV:    state_nxt = ST_DV_LOAD;
      ST_ADDR:    state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_EVAL;
      ST_EVAL:    state_nxt = (idx_r == n_r) ? ST_DONE : ST_ADDR;
      ST_DONE:    if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_tvalid_r  <= 1'b0;
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      cell_size_r   <= CELL_SIZE_RST;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      spacing_r     <= SPACING_RST;
      no_data_r     <= NO_DATA_RST;
      thr_r         <= THRESHOLD_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[15:0];
          REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[15:0];
          REG_CELL_SIZE:   cell_size_r   <= cfg_wdata[30:0];
          REG_ORIGIN_X:    origin_x_r    <= cfg_wdata;
          REG_ORIGIN_Y:    origin_y_r    <= cfg_wdata;
          REG_SPACING:     spacing_r     <= cfg_wdata[30:0];
          REG_NO_DATA:     no_data_r     <= cfg_wdata[7:0];
          REG_THRESHOLD:   thr_r         <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= in_cell_value;
    end
    rdata_r <= grid_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sx_r     <= in_start_x;
        sy_r     <= in_start_y;
        dx_r     <= dx_in;
        dy_r     <= dy_in;
        ax_abs_r <= dx_in[32] ? 32'(-dx_in) : dx_in[31:0];
        ay_abs_r <= dy_in[32] ? 32'(-dy_in) : dy_in[31:0];
        ec_r     <= in_end_clear;
        dv_op_r  <= OP_N;
        pfx_r    <= 1'b1;
        pend_r   <= 1'b0;
        fail_r   <= 1'b0;
        idx_r    <= '0;
        rx_r     <= '0;
        ry_r     <= '0;
      end
      ST_SQ1: sq_rad_r <= mul_p;
      ST_SQ2: begin
        sq_rad_r  <= sq_rad_r + mul_p;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        cnt_r     <= '0;
      end
      ST_SQRT: begin
        sq_rad_r  <= {sq_rad_r[SQW-3:0], 2'b00};
        sq_rem_r  <= sq_rem_nxt;
        sq_root_r <= sq_root_nxt;
        cnt_r     <= cnt_r + CNTW'(1);
        len_r     <= sq_root_nxt;
      end
      ST_DV_LOAD: begin
        dv_num_r <= ld_abs[NMW-1:0];
        dv_neg_r <= ld_num[QW-1];
        dv_den_r <= ld_den;
        dv_rem_r <= '0;
        dv_quo_r <= '0;
        cnt_r    <= '0;
      end
      ST_DV_RUN: begin
        dv_num_r <= {dv_num_r[NMW-2:0], 1'b0};
        dv_rem_r <= dv_rem_nxt;
        dv_quo_r <= {dv_quo_r[NMW-2:0], dv_ge};
        cnt_r    <= cnt_r + CNTW'(1);
      end
      ST_DV_END: begin
        case (dv_op_r)
          OP_N: nq_r <= dv_q;
          OP_DX: begin
            qdx_r   <= dv_q;
            rdx_r   <= dv_r[SW-1:0];
            dv_op_r <= OP_DY;
          end
          OP_DY: begin
            qdy_r   <= dv_q;
            rdy_r   <= dv_r[SW-1:0];
            dv_op_r <= OP_X0;
          end
          OP_X0: begin
            gx_r    <= dv_q;
            offx_r  <= dv_r;
            dv_op_r <= OP_Y0;
          end
          OP_Y0: begin
            gy_r    <= dv_q;
            offy_r  <= dv_r;
            dv_op_r <= OP_AX;
          end
          OP_AX: begin
            stx_r   <= dv_q;
            bx_r    <= dv_r;
            dv_op_r <= OP_AY;
          end
          OP_AY: begin
            sty_r <= dv_q;
            by_r  <= dv_r;
          end
          default: ;
        endcase
      end
      ST_NCHK: begin
        n_r         <= (nq_r == '0) ? SW'(1) : nq_r[SW-1:0];
        res_clear_r <= 1'b0;
        res_tl_r    <= 1'b1;
      end
      ST_ECN: ecn_r <= mul_p[ECW-1:0];
      ST_NLEN: begin
        acc_dn_r <= mul_p[NLW-1:0];
        acc_up_r <= '0;
      end
      ST_MAPV: begin
        map_ok_r <= (cell_size_r != '0) && (grid_width_r != '0) &&
                    (grid_height_r != '0) && (mul_p <= (2*MULW)'(GRID_CELLS));
        dv_op_r  <= OP_DX;
      end
      ST_ADDR: begin
        inb_r    <= inb;
        addr_r   <= AW'(addr_full);
        pfx_ok_r <= acc_up_r < NLW'(ecn_r);
        sfx_ok_r <= acc_dn_r < NLW'(ecn_r);
      end
      ST_EVAL: begin
        pfx_r  <= in_pfx;
        pend_r <= !in_pfx && pend_now;
        fail_r <= fail_nxt;
        // advance the sample point: exact floor(i*d/n) per axis, then cell and offset
        idx_r    <= idx_r + SW'(1);
        acc_up_r <= acc_up_r + NLW'(len_r);
        acc_dn_r <= acc_dn_r - NLW'(len_r);
        rx_r     <= cx ? SW'(rx_sum - {1'b0, n_r}) : SW'(rx_sum);
        ry_r     <= cy ? SW'(ry_sum - {1'b0, n_r}) : SW'(ry_sum);
        offx_r   <= c2x ? 31'(ox_sum - {1'b0, cell_size_r}) : ox_sum[30:0];
        offy_r   <= c2y ? 31'(oy_sum - {1'b0, cell_size_r}) : oy_sum[30:0];
        gx_r     <= gx_r + stx_r + QW'(c2x);
        gy_r     <= gy_r + sty_r + QW'(c2y);
        res_clear_r <= !fail_nxt;
        res_tl_r    <= 1'b0;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_clear_r <= res_clear_r;
          out_tl_r    <= res_tl_r;
        end
      end
      default: ;
    endcase
  end

  `SCC_ASSERT(a_tl_not_clear, clk, rst_n, out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
  `SCC_ASSERT_NEXT(a_busy_after_query, clk, rst_n, query_acc, !in_tready)
  `SCC_ASSERT(a_idx_in_range, clk, rst_n, (state_r == ST_EVAL) |-> (idx_r <= n_r))

endmodule

/* verif/segment_clearance_check_tb.sv */
`timescale 1ns / 1ps

module segment_clearance_check_tb
  import scc_pkg::*;
();

  localparam int LIMIT_CYCLES = 20000000;
  localparam int SETTLE = 50;
  localparam int FILLED = 256;   // cells 0..FILLED-1 are written before any query

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  segment_clearance_check u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor copy of the grid and registers
  logic signed [7:0] grid_mirror [GRID_CELLS_DEF];
  longint map_w, map_h, map_cs, map_ox, map_oy, map_sp, map_nodata, map_thr;

  logic [1:0] verdict_q [$];   // {too_long, clear}
  int errors, queries, writes, results, too_long_seen, clear_seen;
  int tx_idle_pct, rx_idle_pct;
  longint cycles;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d verdicts outstanding", $time, verdict_q.size());
      $display("** segment_clearance_check: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // check each result word against the oldest verdict
  always @(posedge clk) begin
    logic [1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      results++;
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result word: expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want[0]) begin
          $display("%0t clear mismatch: expected %b actual %b", $time, want[0], out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want[1]) begin
          $display("%0t too_long mismatch: expected %b actual %b", $time, want[1], out_tdata[1]);
          errors++;
        end
        if (out_tdata[1]) too_long_seen++;
        if (out_tdata[0]) clear_seen++;
      end
    end
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic bit cell_blocked(longint px, longint py);
    longint gx, gy;
    logic signed [7:0] v;
    if (map_cs == 0 || map_w == 0 || map_h == 0 || map_w * map_h > GRID_CELLS_DEF) return 1;
    gx = floor_quot(px - map_ox, map_cs);
    gy = floor_quot(py - map_oy, map_cs);
    if (gx < 0 || gy < 0 || gx >= map_w || gy >= map_h) return 1;
    v = grid_mirror[gy * map_w + gx];
    return (longint'(v) == map_nodata) || (longint'(v) >= map_thr);
  endfunction

  function automatic logic [1:0] segment_verdict(longint sx, longint sy, longint ex,
                                                 longint ey, longint ec);
    longint dx, dy, ax, ay, len, sp, n, lo, hi;
    logic [69:0] sq, cand;
    logic [34:0] root;
    bit blocked [0:MAX_SAMPLES_DEF];
    dx = ex - sx;
    dy = ey - sy;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sq = 70'(ax) * 70'(ax) + 70'(ay) * 70'(ay);
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = 70'(root | (35'd1 << b));
      if (cand * cand <= sq) root = root | (35'd1 << b);
    end
    len = longint'(root);
    sp = map_sp == 0 ? 1 : map_sp;
    n = (len + sp - 1) / sp;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES_DEF) return 2'b10;
    for (longint i = 0; i <= n; i++)
      blocked[i] = cell_blocked(sx + floor_quot(i * dx, n), sy + floor_quot(i * dy, n));
    // drop occupied runs at either end while inside the end clearance
    lo = 0;
    while (lo <= n && blocked[lo] && lo * len < ec * n) lo++;
    hi = n;
    while (hi >= lo && blocked[hi] && (n - hi) * len < ec * n) hi--;
    for (longint i = lo; i <= hi; i++)
      if (blocked[i]) return 2'b00;
    return 2'b01;
  endfunction

  task automatic send_word(logic cmd, logic [IN_DW-1:0] word);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      grid_mirror[word[15:0]] = word[23:16];
      writes++;
    end else begin
      verdict_q.push_back(segment_verdict(longint'(signed'(word[55:24])),
        longint'(signed'(word[87:56])), longint'(signed'(word[119:88])),
        longint'(signed'(word[151:120])), longint'(word[182:152])));
      queries++;
    end
  endtask

  task automatic write_cell(logic [15:0] idx, logic [7:0] val);
    send_word(CMD_WRITE, IN_DW'({val, idx}));
  endtask

  task automatic query(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey,
                       logic [30:0] ec);
    send_word(CMD_QUERY, IN_DW'({ec, ey, ex, sy, sx, 24'd0}));
  endtask

  task automatic wait_empty();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all eight registers back to back, only while idle
  task automatic load_map(logic [15:0] w, logic [15:0] h, logic [30:0] cs, logic [31:0] ox,
                          logic [31:0] oy, logic [30:0] sp, logic [7:0] nd, logic [6:0] thr);
    logic [31:0] vals [8];
    wait_empty();
    vals[REG_GRID_WIDTH] = 32'(w);
    vals[REG_GRID_HEIGHT] = 32'(h);
    vals[REG_CELL_SIZE] = 32'(cs);
    vals[REG_ORIGIN_X] = ox;
    vals[REG_ORIGIN_Y] = oy;
    vals[REG_SPACING] = 32'(sp);
    vals[REG_NO_DATA] = 32'(nd);
    vals[REG_THRESHOLD] = 32'(thr);
    cfg_we <= 1'b1;
    for (int r = 0; r < 8; r++) begin
      cfg_addr <= CFG_AW'(r);
      cfg_wdata <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    map_w = w; map_h = h; map_cs = cs; map_sp = sp; map_thr = thr;
    map_ox = longint'(signed'(ox));
    map_oy = longint'(signed'(oy));
    map_nodata = longint'(signed'(nd));
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint rand_span(longint span);
    if (span <= 0) return 0;
    return longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span;
  endfunction

  // mostly short segments around the map, some with raw 32-bit coordinates
  task automatic random_query();
    longint cs, sp, cx, cy, reach, k;
    logic [30:0] ec;
    if ($urandom_range(99) < 10) begin
      query($urandom, $urandom, $urandom, $urandom, 31'($urandom));
      return;
    end
    cs = map_cs == 0 ? 65536 : map_cs;
    sp = map_sp == 0 ? 1 : map_sp;
    cx = map_ox - cs + rand_span((map_w + 2) * cs);
    cy = map_oy - cs + rand_span((map_h + 2) * cs);
    k = ($urandom_range(99) < 5) ? $urandom_range(0, 1100) : $urandom_range(0, 200);
    reach = sp * k;
    case ($urandom_range(3))
      0: ec = '0;
      1: ec = 31'($urandom);
      default: ec = 31'(rand_span(reach / 2 + 1));
    endcase
    query(clamp32(cx), clamp32(cy), clamp32(cx + rand_span(2 * reach + 1) - reach),
          clamp32(cy + rand_span(2 * reach + 1) - reach), ec);
  endtask

  task automatic random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(3) == 0) write_cell(16'($urandom), 8'($urandom));
        else write_cell(16'($urandom_range(0, FILLED - 1)), 8'($urandom));
      end else begin
        random_query();
      end
    end
  endtask

  task automatic test_fill_grid();
    for (int i = 0; i < FILLED; i++) begin
      case ($urandom_range(4))
        0: write_cell(16'(i), 8'($urandom));
        1: write_cell(16'(i), 8'sd60);
        default: write_cell(16'(i), 8'($urandom_range(0, 40)));
      endcase
    end
    write_cell(16'hFFFF, 8'h7F);
    write_cell(16'hFFFE, 8'h80);
  endtask

  // 16x16 grid of 1 m cells at the origin
  task automatic test_directed();
    load_map(16'd16, 16'd16, 31'd65536, 32'd0, 32'd0, SPACING_RST, NO_DATA_RST, THRESHOLD_RST);
    for (int c = 0; c < 8; c++) write_cell(16'(c), 8'd0);
    write_cell(16'd3, 8'h80);       // no data in the middle
    write_cell(16'd7, 8'sd50);      // threshold exactly, at the far end
    write_cell(16'd16, 8'h7F);
    // zero length on a free cell, then on a no-data cell
    query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 31'd0);
    query(32'h0003_8000, 32'h0000_8000, 32'h0003_8000, 32'h0000_8000, 31'd0);
    // through the no-data cell
    query(32'h0000_8000, 32'h0000_8000, 32'h0006_8000, 32'h0000_8000, 31'd0);
    // ending on the occupied cell, with and without end clearance, then starting on it
    query(32'h0004_8000, 32'h0000_8000, 32'h0007_8000, 32'h0000_8000, 31'd0);
    query(32'h0004_8000, 32'h0000_8000, 32'h0007_8000, 32'h0000_8000, 31'h0001_8000);
    query(32'h0007_8000, 32'h0000_8000, 32'h0004_8000, 32'h0000_8000, 31'h7FFF_FFFF);
    // leaving the map, start off the map
    query(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_8000, 31'd0);
    query(32'hFFFF_8000, 32'h0000_8000, 32'h0001_8000, 32'h0000_8000, 31'h0000_C000);
    // extremes of the coordinate range: far too many samples
    query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    // just at and just past the sample limit, then a short vertical segment
    query(32'd0, 32'd0, 32'(13107 * 1024), 32'd0, 31'd0);
    query(32'd0, 32'd0, 32'(13107 * 1024 + 1), 32'd0, 31'd0);
    query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_8000, 31'd0);
    wait_empty();
  endtask

  task automatic test_config_extremes();
    load_map(16'd32, 16'd32, 31'd0, 32'd0, 32'd0, SPACING_RST, 8'hFF, 7'd0);
    random_mix(6);
    load_map(16'd0, 16'd16, 31'd65536, 32'd0, 32'd0, SPACING_RST, NO_DATA_RST, 7'd127);
    random_mix(4);
    load_map(16'hFFFF, 16'd2, 31'd65536, 32'd0, 32'd0, SPACING_RST, NO_DATA_RST, 7'd127);
    random_mix(4);
    load_map(16'd16, 16'd0, 31'd65536, 32'd0, 32'd0, SPACING_RST, NO_DATA_RST, 7'd127);
    random_mix(4);
    // zero and one LSB spacing: segments of a few hundred LSB
    load_map(16'd4, 16'd4, 31'd64, 32'hFFFF_FF00, 32'h0000_0100, 31'd0, 8'hFF, 7'd127);
    random_mix(10);
    load_map(16'd16, 16'd16, 31'd1, 32'd0, 32'd0, 31'd1, 8'h80, 7'd0);
    random_mix(10);
    load_map(16'd1, 16'd1, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
             8'h80, THRESHOLD_RST);
    random_mix(10);
    load_map(16'd16, 16'd16, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h4000_0000,
             8'hFF, 7'd127);
    random_mix(10);
  endtask

  task automatic test_random_sender_idle();
    tx_idle_pct = 22;
    rx_idle_pct = 55;
    load_map(16'd16, 16'd16, 31'd65536, 32'hFFF0_0000, 32'h0010_0000, SPACING_RST,
             NO_DATA_RST, THRESHOLD_RST);
    random_mix(50);
    // hold off until every verdict is in, then resume
    wait_empty();
    random_mix(50);
  endtask

  task automatic test_random_receiver_idle();
    tx_idle_pct = 55;
    rx_idle_pct = 22;
    load_map(16'd32, 16'd8, 31'd20000, 32'h8000_0000, 32'h7FF0_0000, 31'd30000,
             8'hC0, 7'd20);
    random_mix(50);
  endtask

  task automatic test_random_streaming();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_map(16'd8, 16'd32, 31'd3277, 32'd0, 32'hFFFE_0000, 31'd2000, 8'hFF, 7'd90);
    random_mix(50);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_WRITE;
    out_tready = 1'b0;
    errors = 0; queries = 0; writes = 0; results = 0; too_long_seen = 0; clear_seen = 0;
    cycles = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    map_w = GRID_WIDTH_RST; map_h = GRID_HEIGHT_RST; map_cs = CELL_SIZE_RST;
    map_ox = 0; map_oy = 0; map_sp = SPACING_RST;
    map_nodata = -128; map_thr = THRESHOLD_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // shrink the map before any query so only filled cells are ever read
    load_map(16'd16, 16'd16, 31'd65536, 32'd0, 32'd0, SPACING_RST, NO_DATA_RST,
             THRESHOLD_RST);
    test_fill_grid();
    test_directed();
    test_config_extremes();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_streaming();
    wait_empty();
    $display("covered %0d cell writes and %0d segment queries over 13 map settings",
             writes, queries);
    $display("verdicts seen: %0d, clear %0d, too long %0d", results, clear_seen, too_long_seen);
    if (errors == 0) begin
      $display("** segment_clearance_check: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** segment_clearance_check: FAILED **");
    end
    $finish;
  end

endmodule
